### rtl/core/dlt_pkg.sv
// dlt_pkg: beat types, request kind codes and reset constants for the lease table
// depends on nothing; used by dlt_ctrl and deadline_lease_table
package dlt_pkg;

   localparam logic [1:0] KIND_ACQUIRE = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_CHECK   = 2'd2;

   localparam logic [15:0] TICKS_RESET = 16'd1000;
   localparam int          MASK_W      = 8;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [31:0]       now_ticks;
      logic [15:0]       hold_units;
      logic signed [3:0] lease_handle;
   } req_beat_type;

   typedef struct packed {
      logic              granted;
      logic [2:0]        slot_index;
      logic              any_live;
      logic [MASK_W-1:0] expired_mask;
      logic              late_release;
   } rsp_beat_type;

   typedef struct packed {
      logic busy;
      logic res_valid;
   } ctrl_status_type;

endpackage

### rtl/core/dlt_deadline_ram.sv
// dlt_deadline_ram: one-write one-read deadline memory, registered read data
// depends on nothing
module dlt_deadline_ram #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] mem [0:DEPTH-1];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/dlt_ctrl.sv
// dlt_ctrl: request sequencer, active marks, deadline arithmetic and expiry scan
// depends on dlt_pkg; drives the ports of dlt_deadline_ram
module dlt_ctrl #(
   parameter int SLOT_COUNT = 8,
   parameter int IDX_W      = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  dlt_pkg::req_beat_type   req,
   input  logic [15:0]             ticks_per_unit,
   input  logic                    res_take,
   output dlt_pkg::ctrl_status_type status,
   output dlt_pkg::rsp_beat_type   res,
   output logic                    ram_wr_en,
   output logic [IDX_W-1:0]        ram_wr_addr,
   output logic [31:0]             ram_wr_data,
   output logic                    ram_rd_en,
   output logic [IDX_W-1:0]        ram_rd_addr,
   input  logic [31:0]             ram_rd_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ACQ    = 2'd1;
   localparam logic [1:0] ST_CHK    = 2'd2;
   localparam logic [1:0] ST_RESULT = 2'd3;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   logic [1:0]              state_ff, state_in;
   logic [SLOT_COUNT-1:0]   active_ff, active_in;
   logic                    issuing_ff, issuing_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   dlt_pkg::req_beat_type   req_ff, req_in;
   dlt_pkg::rsp_beat_type   res_ff, res_in;
   logic [31:0]             prod_ff, prod_in;
   logic [IDX_W-1:0]        free_ff, free_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        scan_ff, scan_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;

   logic [IDX_W-1:0]        free_idx;
   logic                    free_any;
   logic                    hvalid;
   logic [IDX_W-1:0]        hidx;
   logic [31:0]             diff;
   logic [6:0]              free_ext;

   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_idx = IDX_W'(i);
            free_any = 1'b1;
         end
      end
   end

   assign hvalid   = !req.lease_handle[3] && (int'(req.lease_handle[2:0]) < SLOT_COUNT);
   assign hidx     = IDX_W'(req.lease_handle[2:0]);
   assign diff     = req_ff.now_ticks - ram_rd_data;
   assign free_ext = 7'(free_ff);

   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      issuing_in  = issuing_ff;
      cmp_vld_in  = 1'b0;
      req_in      = req_ff;
      res_in      = res_ff;
      prod_in     = prod_ff;
      free_in     = free_ff;
      found_in    = found_ff;
      scan_in     = scan_ff;
      cmp_idx_in  = scan_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = free_ff;
      ram_wr_data = req_ff.now_ticks + prod_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req;
               res_in   = '0;
               prod_in  = 32'(req.hold_units) * 32'(ticks_per_unit);
               free_in  = free_idx;
               found_in = free_any;
               scan_in  = '0;
               unique case (req.req_type)
                  dlt_pkg::KIND_ACQUIRE: begin
                     state_in = ST_ACQ;
                  end
                  dlt_pkg::KIND_RELEASE: begin
                     if (hvalid) begin
                        if (active_ff[hidx]) begin
                           active_in[hidx] = 1'b0;
                        end else begin
                           res_in.late_release = 1'b1;
                        end
                     end
                     state_in = ST_RESULT;
                  end
                  dlt_pkg::KIND_CHECK: begin
                     issuing_in = 1'b1;
                     state_in   = ST_CHK;
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_ACQ: begin
            if (found_ff) begin
               ram_wr_en          = 1'b1;
               active_in[free_ff] = 1'b1;
               res_in.granted     = 1'b1;
               res_in.slot_index  = free_ext[2:0];
            end
            state_in = ST_RESULT;
         end
         ST_CHK: begin
            if (issuing_ff) begin
               ram_rd_en  = 1'b1;
               scan_in    = scan_ff + 1'b1;
               cmp_vld_in = 1'b1;
               if (scan_ff == LAST_IDX) begin
                  issuing_in = 1'b0;
               end
            end
            if (cmp_vld_ff && active_ff[cmp_idx_ff]) begin
               if (!diff[31]) begin
                  active_in[cmp_idx_ff] = 1'b0;
                  for (int b = 0; b < dlt_pkg::MASK_W; b++) begin
                     if (b < SLOT_COUNT && int'(cmp_idx_ff) == b) begin
                        res_in.expired_mask[b] = 1'b1;
                     end
                  end
               end else begin
                  res_in.any_live = 1'b1;
               end
            end
            if (cmp_vld_ff && cmp_idx_ff == LAST_IDX) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         active_ff  <= '0;
         issuing_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         active_ff  <= active_in;
         issuing_ff <= issuing_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      res_ff     <= res_in;
      prod_ff    <= prod_in;
      free_ff    <= free_in;
      found_ff   <= found_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
   end

   assign status.busy      = (state_ff != ST_IDLE);
   assign status.res_valid = (state_ff == ST_RESULT);
   assign res              = res_ff;

endmodule

### rtl/core/deadline_lease_table.sv
// deadline_lease_table: lease slots with wrap-safe deadlines, top level
// depends on dlt_pkg, dlt_ctrl and dlt_deadline_ram
//
//   channel  direction  handshake          beat
//   req      in         req_valid/stall    dlt_pkg::req_beat_type
//   rsp      out        rsp_valid/stall    dlt_pkg::rsp_beat_type
//   csr      in         csr_valid/ready    ticks_per_unit, 16 bits
//
// one request at a time: acquire passes through ST_ACQ, release goes straight to ST_RESULT,
// check scans in ST_CHK, the deadline memory read port scanning one slot a cycle
// a new request is taken while the previous result waits in the output register
// reset (synchronous) clears all active marks and sets ticks_per_unit to 1000
// rsp_stall holds the output register; the sequencer waits only when it is full
module deadline_lease_table #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dlt_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dlt_pkg::rsp_beat_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic [15:0]              ticks_ff, ticks_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   dlt_pkg::rsp_beat_type    rsp_data_ff, rsp_data_in;

   dlt_pkg::ctrl_status_type status;
   dlt_pkg::rsp_beat_type    res;
   logic                     start;
   logic                     res_take;
   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   logic [31:0]              ram_wr_data;
   logic                     ram_rd_en;
   logic [IDX_W-1:0]         ram_rd_addr;
   logic [31:0]              ram_rd_data;

   assign req_stall = status.busy;
   assign start     = req_valid && !status.busy;
   assign csr_ready = 1'b1;
   assign res_take  = status.res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      ticks_in     = ticks_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (csr_valid) begin
         ticks_in = csr_data;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= dlt_pkg::TICKS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   dlt_ctrl #(
      .SLOT_COUNT(SLOT_COUNT),
      .IDX_W     (IDX_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req           (req_data),
      .ticks_per_unit(ticks_ff),
      .res_take      (res_take),
      .status        (status),
      .res           (res),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   dlt_deadline_ram #(
      .DEPTH (SLOT_COUNT),
      .ADDR_W(IDX_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

endmodule
